// ----- hdl/bqn_pkg.sv -----
`default_nettype none

package bqn_pkg;

    // Sample and coefficient formats.
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_BITS      = COEF_FRAC_BITS + 2;

    // Product of one coefficient and one sample, and the sum of five of them.
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A2 = 3'd5;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;

    // Unity gain for b0 after reset.
    localparam coef_t COEF_ONE = {2'b01, {COEF_FRAC_BITS{1'b0}}};

    // Filter history: two past inputs and two past outputs.
    typedef struct packed {
        sample_t x1;
        sample_t x2;
        sample_t y1;
        sample_t y2;
    } hist_t;

    // Normalized filter coefficients.
    typedef struct packed {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1;
        coef_t a2;
    } coefs_t;

endpackage

`default_nettype wire

// ----- hdl/bqn_mac.sv -----
`default_nettype none

module bqn_mac (
    input  var bqn_pkg::sample_t x,
    input  var bqn_pkg::hist_t   hist,
    input  var bqn_pkg::coefs_t  coefs,
    output var bqn_pkg::sample_t y
);
    import bqn_pkg::*;

    // Half an output LSB in the accumulator's fixed-point format.
    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    // Limits of the output sample, in accumulator width.
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [PROD_W-1:0] p_b0;
    logic signed [PROD_W-1:0] p_b1;
    logic signed [PROD_W-1:0] p_b2;
    logic signed [PROD_W-1:0] p_a1;
    logic signed [PROD_W-1:0] p_a2;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  whole;

    // Five products, each exact in its own width.
    assign p_b0 = PROD_W'(coefs.b0) * PROD_W'(x);
    assign p_b1 = PROD_W'(coefs.b1) * PROD_W'(hist.x1);
    assign p_b2 = PROD_W'(coefs.b2) * PROD_W'(hist.x2);
    assign p_a1 = PROD_W'(coefs.a1) * PROD_W'(hist.y1);
    assign p_a2 = PROD_W'(coefs.a2) * PROD_W'(hist.y2);

    // Exact sum plus half an LSB; the arithmetic shift floors, so ties go up.
    assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
               - ACC_W'(p_a1) - ACC_W'(p_a2) + ROUND_HALF;
    assign whole = acc >>> COEF_FRAC_BITS;

    // Saturate to the sample range.
    always_comb
    begin
        priority if (whole > SAT_HI)
        begin
            y = SAMPLE_MAX;
        end
        else if (whole < SAT_LO)
        begin
            y = SAMPLE_MIN;
        end
        else
        begin
            y = whole[SAMPLE_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/biquad_notch_filter.sv -----
// Channel    Direction  Handshake           Payload
// input      in         in_valid/in_stall   sample_in, restart
// output     out        out_valid/out_stall sample_out
// config     in         cfg_we              cfg_index, cfg_data
//
// One beat is taken every cycle while in_stall is low; a result passes from
// the input register through the combinational multiply-accumulate into the
// output register, which also updates the filter history.
// Reset clears the history, sets b0 to unity and the other coefficients to
// zero, and leaves the filter disabled, so samples pass through.
// A stall on the output holds the output register; the input register then
// fills, and in_stall is high while it holds a beat behind a held output.

`default_nettype none

module biquad_notch_filter (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_stall,
    input  wire  [bqn_pkg::SAMPLE_BITS-1:0] sample_in,
    input  wire                             restart,
    output logic                            out_valid,
    input  wire                             out_stall,
    output logic [bqn_pkg::SAMPLE_BITS-1:0] sample_out,
    input  wire                             cfg_we,
    input  wire  [bqn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [bqn_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bqn_pkg::*;

    logic    enable_reg;
    coefs_t  coefs_reg;
    hist_t   hist_reg;
    hist_t   hist_next;
    logic    primed_reg;

    logic    in_valid_reg;
    logic    in_valid_next;
    sample_t x_reg;
    logic    restart_reg;

    logic    out_valid_reg;
    logic    out_valid_next;
    sample_t sample_out_reg;

    logic    out_free;
    logic    in_load;
    logic    out_load;
    logic    bypass;
    sample_t y_filt;
    sample_t y_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            coefs_reg.b0 <= COEF_ONE;
            coefs_reg.b1 <= '0;
            coefs_reg.b2 <= '0;
            coefs_reg.a1 <= '0;
            coefs_reg.a2 <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE:  enable_reg   <= cfg_data[0];
                CFG_COEF_B0: coefs_reg.b0 <= coef_t'(cfg_data);
                CFG_COEF_B1: coefs_reg.b1 <= coef_t'(cfg_data);
                CFG_COEF_B2: coefs_reg.b2 <= coef_t'(cfg_data);
                CFG_COEF_A1: coefs_reg.a1 <= coef_t'(cfg_data);
                CFG_COEF_A2: coefs_reg.a2 <= coef_t'(cfg_data);
                default:     ;
            endcase
        end
    end

    // Pipeline flow: the output register frees up when empty or taken.
    assign out_free       = !out_valid_reg || !out_stall;
    assign in_stall       = in_valid_reg && !out_free;
    assign in_load        = in_valid && !in_stall;
    assign out_load       = in_valid_reg && out_free;
    assign in_valid_next  = in_load || (in_valid_reg && !out_free);
    assign out_valid_next = out_load || (out_valid_reg && !out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            x_reg       <= sample_t'(sample_in);
            restart_reg <= restart;
        end
    end

    // Filter arithmetic.
    bqn_mac u_mac (
        .x     (x_reg),
        .hist  (hist_reg),
        .coefs (coefs_reg),
        .y     (y_filt)
    );

    // Pass through and prime the history when disabled, restarted or unprimed.
    assign bypass = !enable_reg || restart_reg || !primed_reg;
    assign y_next = bypass ? x_reg : y_filt;

    always_comb
    begin
        if (bypass)
        begin
            hist_next.x1 = x_reg;
            hist_next.x2 = x_reg;
            hist_next.y1 = x_reg;
            hist_next.y2 = x_reg;
        end
        else
        begin
            hist_next.x1 = x_reg;
            hist_next.x2 = hist_reg.x1;
            hist_next.y1 = y_filt;
            hist_next.y2 = hist_reg.y1;
        end
    end

    // History advances once per result beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg   <= '0;
            primed_reg <= 1'b0;
        end
        else if (out_load)
        begin
            hist_reg   <= hist_next;
            primed_reg <= 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sample_out_reg <= y_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

`default_nettype wire

// ----- hdl/bqn_checker.sv -----
`default_nettype none

module bqn_checker (
    input wire                             clk,
    input wire                             rst_n,
    input wire                             in_valid,
    input wire                             in_stall,
    input wire                             out_valid,
    input wire                             out_stall,
    input wire  [bqn_pkg::SAMPLE_BITS-1:0] sample_out
);

    // A stalled result beat stays and keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out))
        else $error("stalled output beat changed");

    // With the output register empty, the input side never stalls.
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output register empty");

    // Input stall only comes from a held output beat.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // With in_valid low throughout the antecedent and the output empty at its end, the input
    // register is empty too, so no result beat can appear next.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid ##1 (!in_valid && !out_valid) |=> !out_valid)
        else $error("result beat without an input beat");

endmodule

bind biquad_notch_filter bqn_checker u_bqn_checker (.*);

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    import bqn_pkg::*;

    // Register slots past the last coefficient; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    localparam int  RAND_ITEMS   = 600;
    localparam int  SET_ITEMS    = 40;
    localparam int  HOLD_CYCLES  = 120;
    localparam int  HOLD_AT_ITEM = 445;
    localparam int  DIR_ROWS_N   = 40;

    // One row of the directed table: either a register write or a sample beat.
    typedef enum bit {ROW_ITEM, ROW_REG} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        sample_t               x;
        bit                    rs;
        bit                    known;
        sample_t               want;
    } dir_row_t;

    typedef enum {SET_NOTCH, SET_RANDOM, SET_MAX, SET_MIN, SET_OFF, SET_UNITY} coef_set_e;

    // Directed rows; a known expectation is typed in only where it is obvious.
    localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
        '{ROW_ITEM, CFG_ENABLE,    0,        100,    0, 1, 100},
        '{ROW_ITEM, CFG_ENABLE,    0,        -32768, 0, 1, -32768},
        '{ROW_ITEM, CFG_ENABLE,    0,        32767,  0, 1, 32767},
        '{ROW_ITEM, CFG_ENABLE,    0,        0,      1, 1, 0},
        '{ROW_REG,  CFG_ENABLE,    1,        0,      0, 0, 0},
        '{ROW_ITEM, CFG_ENABLE,    0,        500,    0, 1, 500},
        '{ROW_ITEM, CFG_ENABLE,    0,        -32768, 0, 1, -32768},
        '{ROW_REG,  CFG_COEF_B0,   131071,   0,      0, 0, 0},
        '{ROW_ITEM, CFG_ENABLE,    0,        32767,  0, 1, 32767},
        '{ROW_ITEM, CFG_ENABLE,    0,        -32768, 0, 1, -32768},
        '{ROW_ITEM, CFG_ENABLE,    0,        1,      0, 0, 0},
        '{ROW_REG,  CFG_COEF_B0,   -131072,  0,      0, 0, 0},
        '{ROW_ITEM, CFG_ENABLE,    0,        32767,  0, 1, -32768},
        '{ROW_ITEM, CFG_ENABLE,    0,        -32768, 0, 1, 32767},
        '{ROW_REG,  CFG_COEF_B0,   32768,    0,      0, 0, 0},
        '{ROW_ITEM, CFG_ENABLE,    0,        1,      0, 1, 1},
        '{ROW_ITEM, CFG_ENABLE,    0,        -1,     0, 1, 0},
        '{ROW_ITEM, CFG_ENABLE,    0,        3,      0, 1, 2},
        '{ROW_ITEM, CFG_ENABLE,    0,        -3,     0, 1, -1},
        '{ROW_REG,  CFG_COEF_B0,   65536,    0,      0, 0, 0},
        '{ROW_REG,  CFG_COEF_B1,   65536,    0,      0, 0, 0},
        '{ROW_ITEM, CFG_ENABLE,    0,        7,      1, 1, 7},
        '{ROW_ITEM, CFG_ENABLE,    0,        3,      0, 1, 10},
        '{ROW_REG,  CFG_UNUSED_LO, 0,        0,      0, 0, 0},
        '{ROW_REG,  CFG_UNUSED_HI, 18'h3FFFF, 0,     0, 0, 0},
        '{ROW_ITEM, CFG_ENABLE,    0,        5,      0, 1, 8},
        '{ROW_REG,  CFG_ENABLE,    18'h3FFFE, 0,     0, 0, 0},
        '{ROW_ITEM, CFG_ENABLE,    0,        20,     0, 1, 20},
        '{ROW_REG,  CFG_ENABLE,    1,        0,      0, 0, 0},
        '{ROW_ITEM, CFG_ENABLE,    0,        1,      0, 1, 21},
        '{ROW_REG,  CFG_COEF_B2,   131071,   0,      0, 0, 0},
        '{ROW_REG,  CFG_COEF_A1,   131071,   0,      0, 0, 0},
        '{ROW_REG,  CFG_COEF_A2,   -131072,  0,      0, 0, 0},
        '{ROW_ITEM, CFG_ENABLE,    0,        32767,  0, 0, 0},
        '{ROW_ITEM, CFG_ENABLE,    0,        -32768, 0, 0, 0},
        '{ROW_ITEM, CFG_ENABLE,    0,        0,      0, 0, 0},
        '{ROW_ITEM, CFG_ENABLE,    0,        0,      0, 0, 0},
        '{ROW_REG,  CFG_COEF_A1,   0,        0,      0, 0, 0},
        '{ROW_REG,  CFG_COEF_A2,   0,        0,      0, 0, 0},
        '{ROW_ITEM, CFG_ENABLE,    0,        -12345, 0, 0, 0}
    };

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [SAMPLE_BITS-1:0] sample_in = '0;
    logic                   restart   = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [SAMPLE_BITS-1:0] sample_out;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Filter state as the block should hold it.
    bit      filt_en = 1'b0;
    coefs_t  coefs   = '{COEF_ONE, '0, '0, '0, '0};
    hist_t   hist    = '0;
    bit      primed  = 1'b0;

    sample_t expected_q [$];
    int      send_idle_pct   = 13;
    int      recv_idle_pct   = 47;
    logic    hold_off        = 1'b0;
    int      items_sent      = 0;
    int      rand_items      = 0;
    int      results_checked = 0;
    int      mismatch_count  = 0;
    int      coef_sets       = 0;

    biquad_notch_filter u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    // Next output of the filter for one sample; updates the history.
    function automatic sample_t filter_step(sample_t x, bit rs);
        longint smax = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        longint sum_q;
        longint y;
        if (!filt_en || rs || !primed)
        begin
            hist   = '{x, x, x, x};
            primed = 1'b1;
            return x;
        end
        sum_q = longint'($signed(coefs.b0)) * longint'(x)
              + longint'($signed(coefs.b1)) * longint'(hist.x1)
              + longint'($signed(coefs.b2)) * longint'(hist.x2)
              - longint'($signed(coefs.a1)) * longint'(hist.y1)
              - longint'($signed(coefs.a2)) * longint'(hist.y2);
        // Add half an LSB, then floor: ties go toward plus infinity.
        y = (sum_q + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        if (y > smax)
            y = smax;
        if (y < -smax - 1)
            y = -smax - 1;
        hist.x2 = hist.x1;
        hist.x1 = x;
        hist.y2 = hist.y1;
        hist.y1 = sample_t'(y);
        return sample_t'(y);
    endfunction

    // Register write: one cycle with the enable high, one with it low.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_ENABLE:  filt_en  = data[0];
            CFG_COEF_B0: coefs.b0 = coef_t'(data);
            CFG_COEF_B1: coefs.b1 = coef_t'(data);
            CFG_COEF_B2: coefs.b2 = coef_t'(data);
            CFG_COEF_A1: coefs.a1 = coef_t'(data);
            CFG_COEF_A2: coefs.a2 = coef_t'(data);
            default: ;
        endcase
    endtask

    // Offer one sample beat, with random idle cycles ahead of it.
    task automatic send_sample(sample_t x, bit rs, bit known, sample_t want);
        sample_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= x;
        restart   <= rs;
        do
            @(posedge clk);
        while (in_stall);
        pred = filter_step(x, rs);
        expected_q.push_back(known ? want : pred);
        items_sent++;
    endtask

    // Stop offering and wait until every expected sample has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_q.size() != 0);
    endtask

    // Output side: check each accepted beat, then choose the next stall.
    always @(posedge clk)
    begin
        sample_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: sample_out %0d arrived with nothing pending",
                             $time, $signed(sample_out));
                    mismatch_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    results_checked++;
                    if (sample_t'(sample_out) !== want)
                    begin
                        $display("%0t: sample_out mismatch, expected %0d, got %0d",
                                 $time, want, $signed(sample_out));
                        mismatch_count++;
                    end
                end
            end
            out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Long output hold-off while the sender keeps going, to back up the pipeline.
    initial
    begin
        wait (rand_items >= HOLD_AT_ITEM);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog.
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Main stimulus: directed table, then random coefficient sets.
    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] cset [5];
        coef_set_e             mode;
        longint                unity;
        longint                cosq;
        longint                alpha;
        longint                norm;
        int                    amp;
        bit                    en;
        bit                    rs;
        sample_t               x;

        unity = longint'(COEF_ONE);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_ROWS[i])
        begin
            if (DIR_ROWS[i].kind == ROW_REG)
            begin
                drain_results();
                write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].data);
            end
            else
                send_sample(DIR_ROWS[i].x, DIR_ROWS[i].rs, DIR_ROWS[i].known,
                            DIR_ROWS[i].want);
        end

        for (int p = 0; p < RAND_ITEMS / SET_ITEMS; p++)
        begin
            drain_results();

            // Idle mix: sender light / receiver heavy, then swapped, then none.
            if (rand_items < RAND_ITEMS / 3)
            begin
                send_idle_pct = 13;
                recv_idle_pct = 47;
            end
            else if (rand_items < 2 * RAND_ITEMS / 3)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 13;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (p)
                2:       mode = SET_MAX;
                6:       mode = SET_MIN;
                9:       mode = SET_OFF;
                12:      mode = SET_UNITY;
                default: mode = ($urandom_range(2) != 0) ? SET_NOTCH : SET_RANDOM;
            endcase

            en = (mode != SET_OFF);
            case (mode)
                SET_NOTCH:
                begin
                    // Normalized notch: b0 = b2, b1 = a1, stable poles.
                    cosq    = longint'($urandom_range(0, 131072)) - unity;
                    alpha   = longint'($urandom_range(300, 30000));
                    norm    = unity + alpha;
                    cset[0] = CFG_DATA_W'((unity * unity) / norm);
                    cset[1] = CFG_DATA_W'(-(2 * cosq * unity) / norm);
                    cset[2] = cset[0];
                    cset[3] = cset[1];
                    cset[4] = CFG_DATA_W'(((unity - alpha) * unity) / norm);
                end
                SET_MAX:
                    foreach (cset[k]) cset[k] = {1'b0, {(CFG_DATA_W - 1){1'b1}}};
                SET_MIN:
                    foreach (cset[k]) cset[k] = {1'b1, {(CFG_DATA_W - 1){1'b0}}};
                SET_UNITY:
                begin
                    foreach (cset[k]) cset[k] = '0;
                    cset[0] = COEF_ONE;
                end
                default:
                    foreach (cset[k]) cset[k] = CFG_DATA_W'($urandom);
            endcase

            // Upper bits of the enable write are junk and must be ignored.
            write_reg(CFG_ENABLE, {(CFG_DATA_W - 1)'($urandom), en});
            for (int k = 0; k < 5; k++)
                write_reg(CFG_IDX_W'(CFG_COEF_B0 + k), cset[k]);
            if ($urandom_range(1))
                write_reg($urandom_range(1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                          CFG_DATA_W'($urandom));
            coef_sets++;

            amp = $urandom_range(1, 32767);
            for (int n = 0; n < SET_ITEMS; n++)
            begin
                rs = (n == 0) ? bit'($urandom_range(1)) : ($urandom_range(99) < 3);
                case ($urandom_range(19))
                    0, 1:    x = sample_t'($urandom);
                    2:       x = $urandom_range(1) ? sample_t'(32767) : sample_t'(-32768);
                    default: x = sample_t'(int'($urandom_range(0, 2 * amp)) - amp);
                endcase
                send_sample(x, rs, 1'b0, '0);
                rand_items++;
            end
        end

        drain_results();
        repeat (8) @(posedge clk);

        $display("Covered %0d samples (%0d random) over %0d coefficient sets,",
                 items_sent, rand_items, coef_sets);
        $display("with restarts, disable/re-enable, extreme coefficients and a %0d-cycle hold.",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
